>>> src/kth_ancestor_binary_lifting_assert.svh
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting_assert.svh
// assertion macros for the k-th ancestor block; empty when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef KTH_ANCESTOR_BINARY_LIFTING_ASSERT_SVH
`define KTH_ANCESTOR_BINARY_LIFTING_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define KAB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kab assertion failed");

// antecedent implies consequent in the next cycle
`define KAB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kab assertion failed");

`else

`define KAB_ASSERT_IMP(lbl, ante, cons)
`define KAB_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> src/kab_pkg.sv
// ----------------------------------------------------------------------------
// kab_pkg
// shared constants and types of the k-th ancestor block
// ----------------------------------------------------------------------------
`default_nettype none

package kab_pkg;

  // field widths
  localparam int NODE_W = 10;
  localparam int KIND_W = 2;

  // default sizes
  localparam int DEF_MAX_NODES   = 1024;
  localparam int DEF_LIFT_LEVELS = 10;

  // depth saturates here
  localparam logic [NODE_W-1:0] DEPTH_MAX = '1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_ROOT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ATTACH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // table access strobes from the sequencer
  typedef struct packed {
    logic anc_we;
    logic anc_re;
    logic dep_we;
    logic dep_re;
  } tbl_ctl_t;

endpackage

`default_nettype wire

>>> src/kab_tables.sv
// ----------------------------------------------------------------------------
// kab_tables
// ancestor and depth memories, one write and one registered read port each
// ----------------------------------------------------------------------------
`default_nettype none

module kab_tables
  import kab_pkg::*;
#(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int LIFT_LEVELS = DEF_LIFT_LEVELS,
  parameter int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tbl_ctl_t          ctl,
  input  wire logic [NODE_W-1:0] anc_wnode,
  input  wire logic [LVL_W-1:0]  anc_wlvl,
  input  wire logic [NODE_W-1:0] anc_wdata,
  input  wire logic [NODE_W-1:0] anc_rnode,
  input  wire logic [LVL_W-1:0]  anc_rlvl,
  output logic      [NODE_W-1:0] anc_rdata,
  input  wire logic [NODE_W-1:0] dep_wnode,
  input  wire logic [NODE_W-1:0] dep_wdata,
  input  wire logic [NODE_W-1:0] dep_rnode,
  output logic      [NODE_W-1:0] dep_rdata
);

  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int ANC_DEPTH = MAX_NODES * LIFT_LEVELS;
  localparam int AW        = $clog2(ANC_DEPTH);

  logic [NODE_W-1:0] anc_mem [ANC_DEPTH];
  logic [NODE_W-1:0] dep_mem [MAX_NODES];

  logic [AW-1:0]     anc_waddr;
  logic [AW-1:0]     anc_raddr;
  logic [IDX_W-1:0]  dep_waddr;
  logic [IDX_W-1:0]  dep_raddr;
  logic [NODE_W-1:0] anc_q_r;
  logic [NODE_W-1:0] dep_q_r;
  logic [NODE_W-1:0] fwd_data_r;
  logic              fwd_r;

  // row-major address: node * levels + level
  assign anc_waddr = AW'(IDX_W'(anc_wnode)) * AW'(LIFT_LEVELS) + AW'(anc_wlvl);
  assign anc_raddr = AW'(IDX_W'(anc_rnode)) * AW'(LIFT_LEVELS) + AW'(anc_rlvl);
  assign dep_waddr = IDX_W'(dep_wnode);
  assign dep_raddr = IDX_W'(dep_rnode);

  // ancestor memory
  always_ff @(posedge clk) begin
    if (ctl.anc_we) begin
      anc_mem[anc_waddr] <= anc_wdata;
    end
    if (ctl.anc_re) begin
      anc_q_r    <= anc_mem[anc_raddr];
      fwd_data_r <= anc_wdata;
    end
  end

  // bypass flag for a read that hits the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (ctl.anc_re) begin
      fwd_r <= ctl.anc_we && (anc_waddr == anc_raddr);
    end
  end

  assign anc_rdata = fwd_r ? fwd_data_r : anc_q_r;

  // depth memory
  always_ff @(posedge clk) begin
    if (ctl.dep_we) begin
      dep_mem[dep_waddr] <= dep_wdata;
    end
    if (ctl.dep_re) begin
      dep_q_r <= dep_mem[dep_raddr];
    end
  end

  assign dep_rdata = dep_q_r;

endmodule

`default_nettype wire

>>> src/kab_seq.sv
// ----------------------------------------------------------------------------
// kab_seq
// item sequencer: root fill, level-by-level lifting, query climb, result word
// ----------------------------------------------------------------------------
`default_nettype none

module kab_seq
  import kab_pkg::*;
#(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int LIFT_LEVELS = DEF_LIFT_LEVELS,
  parameter int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [NODE_W-1:0] in_node,
  input  wire logic [NODE_W-1:0] in_parent,
  input  wire logic [NODE_W-1:0] in_steps,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [NODE_W-1:0] out_ancestor,
  output logic                   out_found,
  output tbl_ctl_t               ctl,
  output logic      [NODE_W-1:0] anc_wnode,
  output logic      [LVL_W-1:0]  anc_wlvl,
  output logic      [NODE_W-1:0] anc_wdata,
  output logic      [NODE_W-1:0] anc_rnode,
  output logic      [LVL_W-1:0]  anc_rlvl,
  input  wire logic [NODE_W-1:0] anc_rdata,
  output logic      [NODE_W-1:0] dep_wnode,
  output logic      [NODE_W-1:0] dep_wdata,
  output logic      [NODE_W-1:0] dep_rnode,
  input  wire logic [NODE_W-1:0] dep_rdata
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ROOT   = 8'b0000_0010,
    S_ATT    = 8'b0000_0100,
    S_LIFT   = 8'b0000_1000,
    S_ADEP   = 8'b0001_0000,
    S_QDEP   = 8'b0010_0000,
    S_QCLIMB = 8'b0100_0000,
    S_QDONE  = 8'b1000_0000
  } state_t;

  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LIFT_LEVELS - 1);
  localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

  state_t            state_r, state_nxt;
  logic [LVL_W-1:0]  lv_r, lv_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [NODE_W-1:0] par_r, par_nxt;
  logic [NODE_W-1:0] steps_r, steps_nxt;
  logic [NODE_W-1:0] sh_r, sh_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic              qok_r, qok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_ancestor_r, out_ancestor_nxt;
  logic              out_found_r, out_found_nxt;

  logic              accept;
  logic              node_ok;
  logic              par_ok;
  logic              lv_last;
  logic              out_free;
  logic              hit;
  logic [NODE_W-1:0] climb_v;

  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign node_ok      = (32'(in_node) < MAX_NODES);
  assign par_ok       = (32'(in_parent) < MAX_NODES);
  assign lv_last      = (lv_r == LVL_LAST);
  assign out_free     = !out_valid_r || !out_stall;
  assign hit          = qok_r && (steps_r <= dep_rdata);
  assign climb_v      = sh_r[0] ? anc_rdata : cur_r;

  assign out_valid    = out_valid_r;
  assign out_ancestor = out_ancestor_r;
  assign out_found    = out_found_r;

  // next state, table strobes and addresses
  always_comb begin
    state_nxt        = state_r;
    lv_nxt           = lv_r;
    node_nxt         = node_r;
    par_nxt          = par_r;
    steps_nxt        = steps_r;
    sh_nxt           = sh_r;
    cur_nxt          = cur_r;
    qok_nxt          = qok_r;
    out_valid_nxt    = out_valid_r;
    out_ancestor_nxt = out_ancestor_r;
    out_found_nxt    = out_found_r;
    ctl              = '0;
    anc_wnode        = node_r;
    anc_wlvl         = lv_r;
    anc_wdata        = node_r;
    anc_rnode        = cur_r;
    anc_rlvl         = lv_r;
    dep_wnode        = node_r;
    dep_wdata        = '0;
    dep_rnode        = node_r;

    // result word drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          node_nxt  = in_node;
          par_nxt   = in_parent;
          steps_nxt = in_steps;
          sh_nxt    = in_steps;
          lv_nxt    = '0;
          case (in_kind)
            KIND_ROOT: begin
              if (node_ok) begin
                state_nxt = S_ROOT;
              end
            end
            KIND_ATTACH: begin
              if (node_ok && par_ok) begin
                state_nxt = S_ATT;
              end
            end
            KIND_QUERY: begin
              qok_nxt   = node_ok;
              cur_nxt   = '0;
              state_nxt = node_ok ? S_QDEP : S_QDONE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // every level of the root row points at the root; level zero also sets depth zero
      S_ROOT: begin
        ctl.anc_we = 1'b1;
        anc_wdata  = node_r;
        ctl.dep_we = (lv_r == '0);
        dep_wdata  = '0;
        if (lv_last) begin
          state_nxt = S_IDLE;
        end else begin
          lv_nxt = lv_r + LVL_ONE;
        end
      end

      // level zero is the parent; fetch parent depth and, with more than one level, parent level zero
      S_ATT: begin
        ctl.anc_we = 1'b1;
        anc_wlvl   = '0;
        anc_wdata  = par_r;
        ctl.dep_re = 1'b1;
        dep_rnode  = par_r;
        if (LIFT_LEVELS > 1) begin
          ctl.anc_re = 1'b1;
          anc_rnode  = par_r;
          anc_rlvl   = '0;
          lv_nxt     = LVL_ONE;
          state_nxt  = S_LIFT;
        end else begin
          state_nxt = S_ADEP;
        end
      end

      // write this level and fetch the next one from the value just written
      S_LIFT: begin
        ctl.anc_we = 1'b1;
        anc_wdata  = anc_rdata;
        if (lv_last) begin
          state_nxt = S_ADEP;
        end else begin
          ctl.anc_re = 1'b1;
          anc_rnode  = anc_rdata;
          anc_rlvl   = lv_r;
          lv_nxt     = lv_r + LVL_ONE;
        end
      end

      // child depth is parent depth plus one, saturating
      S_ADEP: begin
        ctl.dep_we = 1'b1;
        dep_wdata  = (dep_rdata == DEPTH_MAX) ? DEPTH_MAX : dep_rdata + NODE_W'(1);
        state_nxt  = S_IDLE;
      end

      // fetch node depth and the first hop
      S_QDEP: begin
        ctl.dep_re = 1'b1;
        dep_rnode  = node_r;
        ctl.anc_re = 1'b1;
        anc_rnode  = node_r;
        anc_rlvl   = '0;
        cur_nxt    = node_r;
        lv_nxt     = '0;
        state_nxt  = S_QCLIMB;
      end

      // take the hop where the step bit is set, prefetch the next level
      S_QCLIMB: begin
        cur_nxt = climb_v;
        sh_nxt  = sh_r >> 1;
        if (lv_last) begin
          state_nxt = S_QDONE;
        end else begin
          ctl.anc_re = 1'b1;
          anc_rnode  = climb_v;
          anc_rlvl   = lv_r + LVL_ONE;
          lv_nxt     = lv_r + LVL_ONE;
        end
      end

      // load the result word once the output register is free
      S_QDONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = hit;
          out_ancestor_nxt = hit ? cur_r : '0;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lv_r           <= lv_nxt;
    node_r         <= node_nxt;
    par_r          <= par_nxt;
    steps_r        <= steps_nxt;
    sh_r           <= sh_nxt;
    cur_r          <= cur_nxt;
    qok_r          <= qok_nxt;
    out_ancestor_r <= out_ancestor_nxt;
    out_found_r    <= out_found_nxt;
  end

endmodule

`default_nettype wire

>>> src/kth_ancestor_binary_lifting.sv
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting
// binary-lifting ancestor table with make-root, attach and k-th ancestor query
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid / in_stall) carry kind, node, parent and steps.
//   One word is taken at a time; in_stall is high while it is processed.
//   Make root writes the root row, one level entry per cycle.
//   In attach, each level needs the ancestor
//   memory read of the level before it, one read per cycle.
//   Query reads the depth, takes one hop per level and loads the result,
//   and gives one result word on out_valid / out_stall;
//   root and attach give none, nor does an unused kind.
//   The result sits in an output register, so the next input word is taken
//   while a result still waits; a stalled result holds the last query.
//   Reset clears the sequencer and the output valid; the ancestor and
//   depth memories are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kth_ancestor_binary_lifting_assert.svh"

module kth_ancestor_binary_lifting
  import kab_pkg::*;
#(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [NODE_W-1:0] in_node,
  input  wire logic [NODE_W-1:0] in_parent,
  input  wire logic [NODE_W-1:0] in_steps,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [NODE_W-1:0] out_ancestor,
  output logic                   out_found
);

  localparam int LVL_W = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;

  tbl_ctl_t          ctl;
  logic [NODE_W-1:0] anc_wnode;
  logic [LVL_W-1:0]  anc_wlvl;
  logic [NODE_W-1:0] anc_wdata;
  logic [NODE_W-1:0] anc_rnode;
  logic [LVL_W-1:0]  anc_rlvl;
  logic [NODE_W-1:0] anc_rdata;
  logic [NODE_W-1:0] dep_wnode;
  logic [NODE_W-1:0] dep_wdata;
  logic [NODE_W-1:0] dep_rnode;
  logic [NODE_W-1:0] dep_rdata;

  // sequencer
  kab_seq #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS),
    .LVL_W       (LVL_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_node      (in_node),
    .in_parent    (in_parent),
    .in_steps     (in_steps),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ancestor (out_ancestor),
    .out_found    (out_found),
    .ctl          (ctl),
    .anc_wnode    (anc_wnode),
    .anc_wlvl     (anc_wlvl),
    .anc_wdata    (anc_wdata),
    .anc_rnode    (anc_rnode),
    .anc_rlvl     (anc_rlvl),
    .anc_rdata    (anc_rdata),
    .dep_wnode    (dep_wnode),
    .dep_wdata    (dep_wdata),
    .dep_rnode    (dep_rnode),
    .dep_rdata    (dep_rdata)
  );

  // ancestor and depth memories
  kab_tables #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS),
    .LVL_W       (LVL_W)
  ) u_tables (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .anc_wnode (anc_wnode),
    .anc_wlvl  (anc_wlvl),
    .anc_wdata (anc_wdata),
    .anc_rnode (anc_rnode),
    .anc_rlvl  (anc_rlvl),
    .anc_rdata (anc_rdata),
    .dep_wnode (dep_wnode),
    .dep_wdata (dep_wdata),
    .dep_rnode (dep_rnode),
    .dep_rdata (dep_rdata)
  );

  // a miss always reports node zero
  `KAB_ASSERT_IMP(a_miss_zero, out_valid && !out_found, out_ancestor == '0)
  // a query word keeps the input side busy in the cycle after it is taken
  `KAB_ASSERT_NXT(a_query_busy, in_valid && !in_stall && in_kind == KIND_QUERY, in_stall)
  // a new result is loaded only as the sequencer goes back to idle
  `KAB_ASSERT_IMP(a_load_idle, $rose(out_valid), !in_stall)

endmodule

`default_nettype wire
